FILE: src/ixl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ixl_pkg
// Shared types and codes for the inline extended-attribute list checker.
// ----------------------------------------------------------------------------
package ixl_pkg;

    // parse phases, also used as the byte role of the same section
    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_NLEN   = 3'd1;
    localparam logic [2:0] PH_VLEN   = 3'd2;
    localparam logic [2:0] PH_FLAGS  = 3'd3;
    localparam logic [2:0] PH_NAME   = 3'd4;
    localparam logic [2:0] PH_PAD    = 3'd5;
    localparam logic [2:0] PH_VALUE  = 3'd6;
    localparam logic [2:0] PH_STOP   = 3'd7;

    localparam logic [2:0] ROLE_IGNORED = 3'd7;

    // parse status codes
    localparam logic [2:0] ST_PARSING  = 3'd0;
    localparam logic [2:0] ST_NOHEAD   = 3'd1;
    localparam logic [2:0] ST_BOUNDS   = 3'd2;
    localparam logic [2:0] ST_BADNAME  = 3'd3;
    localparam logic [2:0] ST_BADVALUE = 3'd4;
    localparam logic [2:0] ST_DONE     = 3'd5;

    // header byte positions
    localparam logic [15:0] HDR_SIZE_HI = 16'd0;
    localparam logic [15:0] HDR_SIZE_LO = 16'd1;
    localparam logic [15:0] HDR_COUNT   = 16'd2;

    localparam int ENTRY_FIXED = 3;

    localparam logic [7:0] PRINT_LO = 8'h20;
    localparam logic [7:0] PRINT_HI = 8'h7E;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 72;

    // one input byte after classification
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        block_start;
        logic [15:0] buffer_length;
        logic        printable;
        logic        is_nul;
    } t_item;

    // one result item
    typedef struct packed {
        logic [7:0]  pad_length;
        logic [7:0]  entry_total;
        logic [15:0] declared_size;
        logic [7:0]  value_length;
        logic [7:0]  name_length;
        logic [7:0]  entry_flag_bits;
        logic        entry_accepted;
        logic [7:0]  entry_number;
        logic [2:0]  parse_status;
        logic [2:0]  byte_role;
    } t_result;

    // queue head handshake between front and back
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_head;

endpackage
`default_nettype wire

FILE: src/ixl_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ixl_front
// Accepts input bytes, tags them as printable or NUL and keeps them in a
// two-entry queue for the parser.
// ----------------------------------------------------------------------------
module ixl_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire  [7:0]           i_data_byte,
    input  wire                  i_block_start,
    input  wire  [15:0]          i_buffer_length,
    output ixl_pkg::t_queue_head o_head,
    input  wire                  i_pop
);

    ixl_pkg::t_item r_mem [2];
    logic           r_wr;
    logic           r_rd;
    logic [1:0]     r_count;
    logic [1:0]     n_count;
    logic           push;
    logic           pop;
    ixl_pkg::t_item new_item;

    assign o_ready = (r_count != 2'd2);
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && (r_count != 2'd0);

    always_comb begin
        new_item.data_byte     = i_data_byte;
        new_item.block_start   = i_block_start;
        new_item.buffer_length = i_buffer_length;
        new_item.printable     = (i_data_byte >= ixl_pkg::PRINT_LO) &&
                                 (i_data_byte <= ixl_pkg::PRINT_HI);
        new_item.is_nul        = (i_data_byte == 8'd0);
    end

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (pop) begin
                r_rd <= ~r_rd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= new_item;
        end
    end

    assign o_head.valid = (r_count != 2'd0);
    assign o_head.item  = r_mem[r_rd];

endmodule
`default_nettype wire

FILE: src/ixl_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ixl_back
// Parser state machine: walks the header and entries one byte per cycle while
// the output is not stalled, and loads the result register.
// ----------------------------------------------------------------------------
module ixl_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire  ixl_pkg::t_queue_head i_head,
    output logic                 o_pop,
    output logic                 o_valid,
    input  wire                  i_ready,
    output ixl_pkg::t_result     o_result
);

    logic [15:0] r_pos, b_pos, n_pos;
    logic [15:0] r_size, b_size, n_size;
    logic [7:0]  r_count, b_count, n_count;
    logic [7:0]  r_pad, b_pad, n_pad;
    logic [7:0]  r_seen, b_seen, n_seen;
    logic [7:0]  r_name, b_name, n_name;
    logic [7:0]  r_value, b_value, n_value;
    logic [7:0]  r_flags, b_flags, n_flags;
    logic [7:0]  r_part, b_part, n_part;
    logic [2:0]  r_phase, b_phase, n_phase;
    logic [2:0]  r_stop, b_stop, n_stop;
    logic [15:0] r_len, b_len;

    logic             r_out_valid;
    ixl_pkg::t_result r_out;
    ixl_pkg::t_result n_out;

    logic        consume;
    logic [7:0]  c;
    logic [2:0]  role;
    logic        accepted;
    logic        adv;
    logic [2:0]  adv_from;
    logic [17:0] end_pos;
    logic        last_byte;
    logic        text_ok;

    assign consume = i_head.valid && (!r_out_valid || i_ready);
    assign o_pop   = consume;
    assign c       = i_head.item.data_byte;

    always_comb begin
        b_pos   = r_pos;
        b_size  = r_size;
        b_count = r_count;
        b_pad   = r_pad;
        b_seen  = r_seen;
        b_name  = r_name;
        b_value = r_value;
        b_flags = r_flags;
        b_part  = r_part;
        b_phase = r_phase;
        b_stop  = r_stop;
        b_len   = r_len;
        // new block: clear everything and sample the buffer length
        if (i_head.item.block_start) begin
            b_pos   = 16'd0;
            b_size  = 16'd0;
            b_count = 8'd0;
            b_pad   = 8'd0;
            b_seen  = 8'd0;
            b_name  = 8'd0;
            b_value = 8'd0;
            b_flags = 8'd0;
            b_part  = 8'd0;
            b_phase = ixl_pkg::PH_HEADER;
            b_stop  = ixl_pkg::ST_PARSING;
            b_len   = i_head.item.buffer_length;
        end
    end

    always_comb begin
        n_pos    = b_pos;
        n_size   = b_size;
        n_count  = b_count;
        n_pad    = b_pad;
        n_seen   = b_seen;
        n_name   = b_name;
        n_value  = b_value;
        n_flags  = b_flags;
        n_part   = b_part;
        n_phase  = b_phase;
        n_stop   = b_stop;
        role     = ixl_pkg::ROLE_IGNORED;
        accepted = 1'b0;
        adv      = 1'b0;
        adv_from = ixl_pkg::PH_NAME;
        end_pos  = 18'(b_pos) + 18'(ixl_pkg::ENTRY_FIXED - 2) + 18'(b_name)
                 + 18'(b_pad) + 18'(c);

        // NUL is allowed only as the last byte of a name or value
        last_byte = 1'b0;
        if (b_phase == ixl_pkg::PH_NAME) begin
            last_byte = ((9'(b_part) + 9'd1) == 9'(b_name));
        end else begin
            last_byte = ((9'(b_part) + 9'd1) == 9'(b_value));
        end
        text_ok = i_head.item.printable || (i_head.item.is_nul && last_byte);

        unique case (b_phase)
            ixl_pkg::PH_HEADER: begin
                role = ixl_pkg::PH_HEADER;
                priority if (b_pos == ixl_pkg::HDR_SIZE_HI) begin
                    n_size = {c, 8'd0};
                end else if (b_pos == ixl_pkg::HDR_SIZE_LO) begin
                    n_size = {b_size[15:8], c};
                    if (n_size == 16'd0 || n_size > b_len) begin
                        n_size  = 16'd0;
                        n_stop  = ixl_pkg::ST_NOHEAD;
                        n_phase = ixl_pkg::PH_STOP;
                    end
                end else if (b_pos == ixl_pkg::HDR_COUNT) begin
                    n_count = c;
                end else begin
                    n_pad = c;
                    if (b_count == 8'd0) begin
                        n_stop  = ixl_pkg::ST_DONE;
                        n_phase = ixl_pkg::PH_STOP;
                    end else begin
                        n_phase = ixl_pkg::PH_NLEN;
                    end
                end
            end
            ixl_pkg::PH_NLEN: begin
                role    = ixl_pkg::PH_NLEN;
                n_name  = c;
                n_value = 8'd0;
                n_flags = 8'd0;
                n_phase = ixl_pkg::PH_VLEN;
            end
            ixl_pkg::PH_VLEN: begin
                role    = ixl_pkg::PH_VLEN;
                n_value = c;
                if (end_pos >= 18'(b_size)) begin
                    n_stop  = ixl_pkg::ST_BOUNDS;
                    n_phase = ixl_pkg::PH_STOP;
                end else begin
                    n_phase = ixl_pkg::PH_FLAGS;
                end
            end
            ixl_pkg::PH_FLAGS: begin
                role     = ixl_pkg::PH_FLAGS;
                n_flags  = c;
                adv      = 1'b1;
                adv_from = ixl_pkg::PH_NAME;
            end
            ixl_pkg::PH_NAME: begin
                role = ixl_pkg::PH_NAME;
                if (!text_ok) begin
                    n_stop  = ixl_pkg::ST_BADNAME;
                    n_phase = ixl_pkg::PH_STOP;
                end else begin
                    n_part   = b_part + 8'd1;
                    adv      = (n_part == b_name);
                    adv_from = ixl_pkg::PH_PAD;
                end
            end
            ixl_pkg::PH_PAD: begin
                role     = ixl_pkg::PH_PAD;
                n_part   = b_part + 8'd1;
                adv      = (n_part == b_pad);
                adv_from = ixl_pkg::PH_VALUE;
            end
            ixl_pkg::PH_VALUE: begin
                role = ixl_pkg::PH_VALUE;
                if (!text_ok) begin
                    n_stop  = ixl_pkg::ST_BADVALUE;
                    n_phase = ixl_pkg::PH_STOP;
                end else begin
                    n_part   = b_part + 8'd1;
                    adv      = (n_part == b_value);
                    adv_from = ixl_pkg::PH_STOP;
                end
            end
            default: begin
                role = ixl_pkg::ROLE_IGNORED;
            end
        endcase

        // enter the next non-empty section, or close the entry
        if (adv) begin
            n_part = 8'd0;
            priority if (adv_from <= ixl_pkg::PH_NAME && n_name != 8'd0) begin
                n_phase = ixl_pkg::PH_NAME;
            end else if (adv_from <= ixl_pkg::PH_PAD && n_pad != 8'd0) begin
                n_phase = ixl_pkg::PH_PAD;
            end else if (adv_from <= ixl_pkg::PH_VALUE && n_value != 8'd0) begin
                n_phase = ixl_pkg::PH_VALUE;
            end else begin
                n_seen   = b_seen + 8'd1;
                accepted = 1'b1;
                if (n_seen == n_count) begin
                    n_stop  = ixl_pkg::ST_DONE;
                    n_phase = ixl_pkg::PH_STOP;
                end else begin
                    n_phase = ixl_pkg::PH_NLEN;
                end
            end
        end

        if (b_pos != 16'hFFFF) begin
            n_pos = b_pos + 16'd1;
        end

        n_out.byte_role       = role;
        n_out.parse_status    = n_stop;
        n_out.entry_number    = b_seen;
        n_out.entry_accepted  = accepted;
        n_out.entry_flag_bits = n_flags;
        n_out.name_length     = n_name;
        n_out.value_length    = n_value;
        n_out.declared_size   = n_size;
        n_out.entry_total     = n_count;
        n_out.pad_length      = n_pad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= 16'd0;
            r_size      <= 16'd0;
            r_count     <= 8'd0;
            r_pad       <= 8'd0;
            r_seen      <= 8'd0;
            r_name      <= 8'd0;
            r_value     <= 8'd0;
            r_flags     <= 8'd0;
            r_part      <= 8'd0;
            r_phase     <= ixl_pkg::PH_HEADER;
            r_stop      <= ixl_pkg::ST_PARSING;
            r_len       <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (consume) begin
                r_pos   <= n_pos;
                r_size  <= n_size;
                r_count <= n_count;
                r_pad   <= n_pad;
                r_seen  <= n_seen;
                r_name  <= n_name;
                r_value <= n_value;
                r_flags <= n_flags;
                r_part  <= n_part;
                r_phase <= n_phase;
                r_stop  <= n_stop;
                r_len   <= b_len;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule
`default_nettype wire

FILE: src/inline_xattr_list_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// inline_xattr_list_checker
// Byte-wise checker for an inline extended-attribute block.
// ----------------------------------------------------------------------------
// Feed the block one byte per item, with tuser high on the first byte of each
// block; that byte also carries the buffer length. Every input item yields
// exactly one result item telling the byte's role and the parse status after
// it. The block sustains one item per clock while the output is not stalled:
// the parser state machine updates all its counters for one byte at once. A
// result item is offered once its byte has been written into the input queue
// and the parser has then taken it and loaded the result register; a
// two-entry queue between intake and parser lets each side stall without
// losing rate.
module inline_xattr_list_checker (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] data_byte, [23:8] buffer_length
    input  wire  [ixl_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // [0] block_start
    input  wire         s_axis_tuser,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // [2:0] byte_role, [5:3] parse_status, [13:6] entry_number,
    // [14] entry_accepted, [22:15] entry_flag_bits, [30:23] name_length,
    // [38:31] value_length, [54:39] declared_size, [62:55] entry_total,
    // [70:63] pad_length, [71] zero
    output logic [ixl_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    ixl_pkg::t_queue_head head;
    logic                 pop;
    ixl_pkg::t_result     result;

    ixl_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (s_axis_tvalid),
        .o_ready         (s_axis_tready),
        .i_data_byte     (s_axis_tdata[7:0]),
        .i_block_start   (s_axis_tuser),
        .i_buffer_length (s_axis_tdata[23:8]),
        .o_head          (head),
        .i_pop           (pop)
    );

    ixl_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    assign m_axis_tdata = {1'b0, result};

`ifndef SYNTHESIS
    a_accept_role : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && result.entry_accepted) |->
            (result.byte_role == ixl_pkg::PH_FLAGS || result.byte_role == ixl_pkg::PH_NAME ||
             result.byte_role == ixl_pkg::PH_PAD || result.byte_role == ixl_pkg::PH_VALUE))
        else $error("entry accepted on a byte outside an entry body");

    a_ignored_stopped : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && result.byte_role == ixl_pkg::ROLE_IGNORED) |->
            (result.parse_status != ixl_pkg::ST_PARSING))
        else $error("ignored byte while still parsing");

    a_done_source : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && result.parse_status == ixl_pkg::ST_DONE) |->
            (result.entry_accepted || result.byte_role == ixl_pkg::PH_HEADER ||
             result.byte_role == ixl_pkg::ROLE_IGNORED))
        else $error("done status without a closing byte");

    a_pop_has_item : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> head.valid)
        else $error("parser took an item from an empty queue");
`endif

endmodule
`default_nettype wire
